// ===== rtl/iia_pkg.sv =====
// Package for the indexed insert/remove array unit.
// Holds sizes, mode and status codes, controller states and control structs.
// No dependencies.
package iia_pkg;

    localparam int DEPTH    = 64;
    localparam int WORD_W   = 32;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int MODE_W   = 2;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = ((MODE_W + IDX_W + WORD_W + 7) / 8) * 8;
    localparam int M_RAW_W  = WORD_W + CNT_W + STAT_W;
    localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] MODE_READ   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS,
        S_RD_CAP,
        S_REM,
        S_FINISH
    } iia_state_t;

    typedef struct packed {
        logic              load;
        logic              set_stat;
        logic [STAT_W-1:0] stat_code;
        logic              init_ins;
        logic              init_rem;
        logic              rd_idx;
        logic              cap_res;
        logic              step;
        logic              ins_done;
        logic              rem_done;
        logic              out_load;
    } iia_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              in_range;
        logic              shift_done;
        logic              out_free;
    } iia_stat_t;

endpackage

// ===== rtl/iia_ctrl.sv =====
// Controller for the indexed insert/remove array unit.
// Sequences decode, shift, read and result load; drives the datapath via iia_cmd_t.
// Depends on iia_pkg.
module iia_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  iia_pkg::iia_stat_t stat,
    output iia_pkg::iia_cmd_t  cmd
);

    iia_pkg::iia_state_t state_reg;
    iia_pkg::iia_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= iia_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            iia_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = iia_pkg::S_DECODE;
                end
            end
            iia_pkg::S_DECODE: begin
                case (stat.mode)
                    iia_pkg::MODE_INSERT: begin
                        state_next = stat.full ? iia_pkg::S_FINISH : iia_pkg::S_INS;
                    end
                    iia_pkg::MODE_READ, iia_pkg::MODE_REMOVE: begin
                        state_next = stat.in_range ? iia_pkg::S_RD_CAP : iia_pkg::S_FINISH;
                    end
                    default: begin
                        state_next = iia_pkg::S_FINISH;
                    end
                endcase
            end
            iia_pkg::S_RD_CAP: begin
                state_next = (stat.mode == iia_pkg::MODE_REMOVE) ? iia_pkg::S_REM
                                                                 : iia_pkg::S_FINISH;
            end
            iia_pkg::S_INS, iia_pkg::S_REM: begin
                if (stat.shift_done) begin
                    state_next = iia_pkg::S_FINISH;
                end
            end
            iia_pkg::S_FINISH: begin
                if (stat.out_free) begin
                    state_next = iia_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = iia_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            iia_pkg::S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            iia_pkg::S_DECODE: begin
                cmd.set_stat  = 1'b1;
                cmd.stat_code = iia_pkg::STAT_OK;
                case (stat.mode)
                    iia_pkg::MODE_INSERT: begin
                        if (stat.full) begin
                            cmd.stat_code = iia_pkg::STAT_FULL;
                        end else begin
                            cmd.init_ins = 1'b1;
                        end
                    end
                    iia_pkg::MODE_READ, iia_pkg::MODE_REMOVE: begin
                        if (!stat.in_range) begin
                            cmd.stat_code = iia_pkg::STAT_RANGE;
                        end else begin
                            cmd.rd_idx   = 1'b1;
                            cmd.init_rem = (stat.mode == iia_pkg::MODE_REMOVE);
                        end
                    end
                    default: begin
                        cmd.stat_code = iia_pkg::STAT_OK;
                    end
                endcase
            end
            iia_pkg::S_RD_CAP: begin
                cmd.cap_res = 1'b1;
            end
            iia_pkg::S_INS: begin
                cmd.step     = !stat.shift_done;
                cmd.ins_done = stat.shift_done;
            end
            iia_pkg::S_REM: begin
                cmd.step     = !stat.shift_done;
                cmd.rem_done = stat.shift_done;
            end
            iia_pkg::S_FINISH: begin
                cmd.out_load = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/iia_dp.sv =====
// Datapath for the indexed insert/remove array unit.
// Entry memory, count, shift pointer with pipelined move, and the result register.
// Depends on iia_pkg.
module iia_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [iia_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [iia_pkg::M_DATA_W-1:0]   m_tdata,
    input  iia_pkg::iia_cmd_t              cmd,
    output iia_pkg::iia_stat_t             stat
);

    localparam int IW = iia_pkg::IDX_W;
    localparam int CW = iia_pkg::CNT_W;
    localparam int WW = iia_pkg::WORD_W;

    logic [WW-1:0] mem [iia_pkg::DEPTH];

    logic [iia_pkg::MODE_W-1:0] mode_reg;
    logic [IW-1:0]              idx_reg;
    logic [WW-1:0]              word_reg;
    logic [CW-1:0]              cnt_reg;
    logic [CW-1:0]              ptr_reg;
    logic [CW-1:0]              lim_reg;
    logic                       wr_pend_reg;
    logic [IW-1:0]              wr_addr_reg;
    logic [WW-1:0]              rd_data_reg;
    logic [WW-1:0]              res_reg;
    logic [iia_pkg::STAT_W-1:0] st_reg;
    logic                       out_valid_reg;
    logic [iia_pkg::M_DATA_W-1:0] out_data_reg;

    logic [CW-1:0] idx_ext;
    logic [CW-1:0] ptr_dec;
    logic [CW-1:0] cnt_dec;
    logic          is_ins;
    logic          more;
    logic [IW-1:0] rd_addr;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [WW-1:0] mem_wd;

    assign idx_ext = {{(CW-IW){1'b0}}, idx_reg};
    assign ptr_dec = ptr_reg - CW'(1);
    assign cnt_dec = cnt_reg - CW'(1);
    assign is_ins  = (mode_reg == iia_pkg::MODE_INSERT);
    assign more    = (ptr_reg != lim_reg);

    always_comb begin
        if (cmd.rd_idx) begin
            rd_addr = idx_reg;
        end else if (is_ins) begin
            rd_addr = ptr_dec[IW-1:0];
        end else begin
            rd_addr = ptr_reg[IW-1:0];
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = wr_addr_reg;
        mem_wd = rd_data_reg;
        if (cmd.step && wr_pend_reg) begin
            mem_we = 1'b1;
        end else if (cmd.ins_done) begin
            mem_we = 1'b1;
            mem_wa = lim_reg[IW-1:0];
            mem_wd = word_reg;
        end else if (cmd.rem_done) begin
            mem_we = 1'b1;
            mem_wa = cnt_dec[IW-1:0];
            mem_wd = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // item, status, result, shift and output payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= s_tdata[iia_pkg::MODE_W-1:0];
            idx_reg  <= s_tdata[iia_pkg::MODE_W +: IW];
            word_reg <= s_tdata[iia_pkg::MODE_W + IW +: WW];
        end
        if (cmd.set_stat) begin
            st_reg  <= cmd.stat_code;
            res_reg <= '0;
        end
        if (cmd.cap_res) begin
            res_reg <= rd_data_reg;
        end
        if (cmd.init_ins) begin
            ptr_reg <= cnt_reg;
            lim_reg <= (idx_ext > cnt_reg) ? cnt_reg : idx_ext;
        end else if (cmd.init_rem) begin
            ptr_reg <= idx_ext + CW'(1);
            lim_reg <= cnt_reg;
        end else if (cmd.step && more) begin
            ptr_reg     <= is_ins ? ptr_dec : ptr_reg + CW'(1);
            wr_addr_reg <= is_ins ? ptr_reg[IW-1:0] : ptr_dec[IW-1:0];
        end
        if (cmd.out_load) begin
            out_data_reg <= iia_pkg::M_DATA_W'({st_reg, cnt_reg, res_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.ins_done) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (cmd.rem_done) begin
                cnt_reg <= cnt_dec;
            end
            if (cmd.init_ins || cmd.init_rem) begin
                wr_pend_reg <= 1'b0;
            end else if (cmd.step) begin
                wr_pend_reg <= more;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.mode       = mode_reg;
    assign stat.full       = (cnt_reg == CW'(iia_pkg::DEPTH));
    assign stat.in_range   = (idx_ext < cnt_reg);
    assign stat.shift_done = !more && !wr_pend_reg;
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/indexed_insert_remove_array_unit.sv =====
// Indexed insert/remove array unit: an ordered store of up to 64 words with a count.
// Slave beat on s_*: mode, index and data word. Master beat on m_*: data_out,
// count after the operation, status (ok, store full, index not below count).
// Reads and removes fetch the entry through a registered memory read; inserts and
// removes then move the following entries one per cycle through the single write
// port of the entry memory, pipelined behind its read port.
// A flagged or unused-mode item goes straight to its result; an insert moves
// count - clamped index entries, a remove count - index - 1 entries, and the
// longest item is a remove at index 0 of a full store. One item is in work at a
// time; the next beat can be taken from the cycle in which m_tvalid rises.
// s_tready is high only while the unit is idle, including while a finished
// result still waits on m_*.
// A stalled result holds in the output register; a new item may then run up to its
// result and waits there until the output register frees.
// Reset (aresetn low at a clock edge) empties the store and drops any pending
// result; memory contents are not cleared and are never returned before written.
// Depends on iia_pkg, iia_ctrl and iia_dp.
module indexed_insert_remove_array_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [1:0] mode, [7:2] index, [39:8] data_in
    input  logic [iia_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [31:0] data_out, [38:32] count, [40:39] status, [47:41] zero
    output logic [iia_pkg::M_DATA_W-1:0] m_tdata
);

    iia_pkg::iia_cmd_t  cmd;
    iia_pkg::iia_stat_t stat;

    iia_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    iia_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
